[hw/rtl/errq_pkg.sv]
// Package for the error aggregator with de-duplicating handler queue.
// Holds sizes, command and display codes, and the control state type.
// Depends on nothing; used by error_aggregator_dedup_queue.
package errq_pkg;

    localparam int SOURCES = 20;
    localparam int QSIZE   = SOURCES + 1;

    localparam int SRC_W  = 5;
    localparam int CODE_W = 3;
    localparam int KIND_W = 2;

    localparam int SRC_AW = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int Q_AW   = $clog2(QSIZE);

    typedef enum logic [1:0] {
        CMD_REPORT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_TICK   = 2'd2
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        SHOW_NONE  = 2'd0,
        SHOW_BLANK = 2'd1,
        SHOW_ERROR = 2'd2
    } t_kind;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

[hw/rtl/error_aggregator_dedup_queue.sv]
// Error aggregator with a de-duplicating handler queue.
// Holds the code memory, the pending-source ring and the control state machine.
// Depends on errq_pkg.

// Collects error reports from errq_pkg::SOURCES sources. A report with a nonzero
// code stores the code, marks the source active and queues it for handling unless
// it is already queued; a report with code zero or a clear command drops the
// source's code and active flag. A tick shows the lowest-numbered active source
// and its code (or a blank when none is active), then pops one queued source and
// clears it. Sources at or above errq_pkg::SOURCES are ignored. Every transfer
// in produces exactly one transfer out. For a report or clear, its writes to
// the code memory and the ring land at the input transfer and the result is
// registered at the same edge. A tick, and the unused command code, go through
// the read state: the code memory and the ring have a synchronous read, so the
// idle state issues the reads (lowest active source, input source, ring head)
// and the read state applies the pop and registers the result. The block takes
// one item at a time; a new item is taken only in the idle state, when the
// output register is empty or its result is being transferred out. Code memory
// entries need no clearing pass: a stored code is valid only while the source's
// active flag is set, so a read is masked by that flag, which reset clears.
module error_aggregator_dedup_queue (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [1:0]                             i_cmd,
    input  logic [errq_pkg::SRC_W-1:0]             i_source,
    input  logic [errq_pkg::CODE_W-1:0]            i_code,

    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [errq_pkg::KIND_W-1:0]            o_shown_kind,
    output logic [errq_pkg::SRC_W-1:0]             o_shown_source,
    output logic [errq_pkg::CODE_W-1:0]            o_shown_code,
    output logic                                   o_handled_valid,
    output logic [errq_pkg::SRC_W-1:0]             o_handled_source,
    output logic [errq_pkg::SOURCES-1:0]           o_active_mask,
    output logic [errq_pkg::CODE_W-1:0]            o_source_code_now
);

    // Storage: code per source, and the ring of pending sources.
    logic [errq_pkg::CODE_W-1:0] code_mem [errq_pkg::SOURCES];
    logic [errq_pkg::SRC_W-1:0]  ring_mem [errq_pkg::QSIZE];

    errq_pkg::t_state r_state, n_state;

    logic [errq_pkg::SOURCES-1:0] r_active, n_active;
    logic [errq_pkg::SOURCES-1:0] r_queued, n_queued;
    logic [errq_pkg::Q_AW-1:0]    r_head, n_head;
    logic [errq_pkg::Q_AW-1:0]    r_tail, n_tail;

    // Read-stage context captured at the input transfer.
    logic                         r_is_tick;
    logic                         r_src_ok;
    logic [errq_pkg::SRC_AW-1:0]  r_src_idx;
    logic [errq_pkg::SRC_AW-1:0]  r_show_idx;
    logic                         r_any_active;

    // Registered memory read data.
    logic [errq_pkg::CODE_W-1:0]  r_rd_show;
    logic [errq_pkg::CODE_W-1:0]  r_rd_src;
    logic [errq_pkg::SRC_W-1:0]   r_rd_ring;

    // Output register.
    logic                         r_out_valid, n_out_valid;
    logic [errq_pkg::KIND_W-1:0]  r_kind, n_kind;
    logic [errq_pkg::SRC_W-1:0]   r_shown_src, n_shown_src;
    logic [errq_pkg::CODE_W-1:0]  r_shown_code, n_shown_code;
    logic                         r_hv, n_hv;
    logic [errq_pkg::SRC_W-1:0]   r_hs, n_hs;
    logic [errq_pkg::SOURCES-1:0] r_mask, n_mask;
    logic [errq_pkg::CODE_W-1:0]  r_now, n_now;

    logic                         in_xfer;
    logic                         out_xfer;
    errq_pkg::t_cmd               cmd;
    logic                         src_ok;
    logic [errq_pkg::SRC_AW-1:0]  src_idx;
    logic                         do_set;
    logic                         do_clear;
    logic                         do_enq;
    logic                         do_read;
    logic                         do_pop;
    logic [errq_pkg::SRC_AW-1:0]  pop_idx;
    logic [errq_pkg::Q_AW-1:0]    tail_inc;
    logic [errq_pkg::Q_AW-1:0]    head_inc;
    logic                         ring_full;
    logic [errq_pkg::SRC_AW-1:0]  low_idx;
    logic                         code_we;
    logic [errq_pkg::SRC_AW-1:0]  code_wa;
    logic [errq_pkg::CODE_W-1:0]  code_wd;
    logic [errq_pkg::Q_AW-1:0]    ring_occ;

    // Lowest set bit of the active flags; priority loop from the top bit down.
    function automatic logic [errq_pkg::SRC_AW-1:0] lowest_set(
        input logic [errq_pkg::SOURCES-1:0] bits
    );
        logic [errq_pkg::SRC_AW-1:0] idx;
        idx = '0;
        for (int i = errq_pkg::SOURCES - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = errq_pkg::SRC_AW'(i);
            end
        end
        return idx;
    endfunction

    // ---------------- Handshake and command decode ----------------
    assign o_in_ready = (r_state == errq_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_xfer   = r_out_valid && i_out_ready;

    assign cmd     = errq_pkg::t_cmd'(i_cmd);
    assign src_ok  = {1'b0, i_source} < (errq_pkg::SRC_W + 1)'(errq_pkg::SOURCES);
    assign src_idx = i_source[errq_pkg::SRC_AW-1:0];
    assign low_idx = lowest_set(r_active);

    always_comb begin
        do_set   = 1'b0;
        do_clear = 1'b0;
        do_read  = 1'b0;
        unique case (cmd)
            errq_pkg::CMD_REPORT: begin
                do_set   = in_xfer && src_ok && (i_code != '0);
                do_clear = in_xfer && src_ok && (i_code == '0);
            end
            errq_pkg::CMD_CLEAR: begin
                do_clear = in_xfer && src_ok;
            end
            default: begin
                // Tick and the unused code both need the read stage.
                do_read = in_xfer;
            end
        endcase
    end

    // ---------------- Ring pointers ----------------
    assign tail_inc  = (r_tail == errq_pkg::Q_AW'(errq_pkg::QSIZE - 1)) ? '0 : r_tail + 1'b1;
    assign head_inc  = (r_head == errq_pkg::Q_AW'(errq_pkg::QSIZE - 1)) ? '0 : r_head + 1'b1;
    assign ring_full = (tail_inc == r_head);
    assign do_enq    = do_set && !r_queued[src_idx] && !ring_full;

    // Pop happens in the read stage of a tick when the ring holds anything.
    assign do_pop  = (r_state == errq_pkg::S_READ) && r_is_tick && (r_head != r_tail);
    assign pop_idx = r_rd_ring[errq_pkg::SRC_AW-1:0];

    always_comb begin
        n_active = r_active;
        n_queued = r_queued;
        n_head   = r_head;
        n_tail   = r_tail;
        if (do_set) begin
            n_active[src_idx] = 1'b1;
        end
        if (do_clear) begin
            n_active[src_idx] = 1'b0;
        end
        if (do_enq) begin
            n_queued[src_idx] = 1'b1;
            n_tail            = tail_inc;
        end
        if (do_pop) begin
            n_active[pop_idx] = 1'b0;
            n_queued[pop_idx] = 1'b0;
            n_head            = head_inc;
        end
    end

    // ---------------- Code memory write port ----------------
    // Pop and input-side writes never fall in the same cycle.
    always_comb begin
        code_we = do_pop || do_set || do_clear;
        code_wa = do_pop ? pop_idx : src_idx;
        code_wd = (do_set && !do_pop) ? i_code : '0;
    end

    always_ff @(posedge i_clk) begin
        if (code_we) begin
            code_mem[code_wa] <= code_wd;
        end
        r_rd_show <= code_mem[low_idx];
        r_rd_src  <= code_mem[src_idx];
    end

    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            ring_mem[r_tail] <= i_source;
        end
        r_rd_ring <= ring_mem[r_head];
    end

    // ---------------- State machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            errq_pkg::S_IDLE: begin
                if (do_read) begin
                    n_state = errq_pkg::S_READ;
                end
            end
            errq_pkg::S_READ: begin
                n_state = errq_pkg::S_IDLE;
            end
            default: begin
                n_state = errq_pkg::S_IDLE;
            end
        endcase
    end

    // Result build: input side for report/clear, read stage otherwise.
    always_comb begin
        n_out_valid  = r_out_valid && !out_xfer;
        n_kind       = r_kind;
        n_shown_src  = r_shown_src;
        n_shown_code = r_shown_code;
        n_hv         = r_hv;
        n_hs         = r_hs;
        n_mask       = r_mask;
        n_now        = r_now;
        unique case (r_state)
            errq_pkg::S_IDLE: begin
                if (in_xfer && !do_read) begin
                    n_out_valid  = 1'b1;
                    n_kind       = errq_pkg::SHOW_NONE;
                    n_shown_src  = '0;
                    n_shown_code = '0;
                    n_hv         = 1'b0;
                    n_hs         = '0;
                    n_mask       = n_active;
                    n_now        = do_set ? i_code : '0;
                end
            end
            errq_pkg::S_READ: begin
                n_out_valid = 1'b1;
                if (!r_is_tick) begin
                    n_kind = errq_pkg::SHOW_NONE;
                end else if (r_any_active) begin
                    n_kind = errq_pkg::SHOW_ERROR;
                end else begin
                    n_kind = errq_pkg::SHOW_BLANK;
                end
                n_shown_src  = (r_is_tick && r_any_active) ?
                               errq_pkg::SRC_W'(r_show_idx) : '0;
                n_shown_code = (r_is_tick && r_any_active) ? r_rd_show : '0;
                n_hv         = do_pop;
                n_hs         = do_pop ? r_rd_ring : '0;
                n_mask       = n_active;
                // Mask by the pre-pop active flag; drop the code if it was just popped.
                n_now        = (r_src_ok && r_active[r_src_idx] &&
                                !(do_pop && (pop_idx == r_src_idx))) ? r_rd_src : '0;
            end
            default: begin
                n_out_valid = 1'b0;
            end
        endcase
    end

    // ---------------- Registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= errq_pkg::S_IDLE;
            r_active    <= '0;
            r_queued    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_queued    <= n_queued;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_read) begin
            r_is_tick    <= (cmd == errq_pkg::CMD_TICK);
            r_src_ok     <= src_ok;
            r_src_idx    <= src_idx;
            r_show_idx   <= low_idx;
            r_any_active <= (r_active != '0);
        end
        r_kind       <= n_kind;
        r_shown_src  <= n_shown_src;
        r_shown_code <= n_shown_code;
        r_hv         <= n_hv;
        r_hs         <= n_hs;
        r_mask       <= n_mask;
        r_now        <= n_now;
    end

    assign o_out_valid       = r_out_valid;
    assign o_shown_kind      = r_kind;
    assign o_shown_source    = r_shown_src;
    assign o_shown_code      = r_shown_code;
    assign o_handled_valid   = r_hv;
    assign o_handled_source  = r_hs;
    assign o_active_mask     = r_mask;
    assign o_source_code_now = r_now;

    // ---------------- Assertions ----------------
    assign ring_occ = (r_tail >= r_head) ? (r_tail - r_head) :
                      (r_tail + errq_pkg::Q_AW'(errq_pkg::QSIZE) - r_head);

    // Every queued flag has exactly one ring entry.
    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_queued) == int'(ring_occ))
        else $error("queued flags disagree with ring occupancy");

    // The read stage lands its result in an empty output register.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == errq_pkg::S_READ) |-> !r_out_valid)
        else $error("read-stage result would overwrite a pending result");

    // A pop removes exactly one queued flag.
    a_pop_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> ($countones(r_queued) == $past($countones(r_queued)) - 1))
        else $error("pop did not remove exactly one queued source");

    // A transfer needing a read goes to the read stage and returns to idle.
    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_read |=> (r_state == errq_pkg::S_READ) ##1 (r_state == errq_pkg::S_IDLE))
        else $error("read stage sequence broken");

endmodule
